/* rtl/fbph_pkg.sv */
// Shared types, constants and the base lookup for the FASTQ prefix histogram.
package fbph_pkg;

  localparam int PREFIX_LEN  = 4;
  localparam int SYMBOL_BITS = 3;
  localparam int CODE_BITS   = 12;
  localparam int COUNT_BITS  = 32;
  localparam int CFG_BITS    = 16;
  localparam int SKIP_BITS   = 17;
  localparam int POS_BITS    = 3;
  localparam int STORE_DEPTH = 4096;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_N  = 8'h4E;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_NEW_FILE = 2'd1,
    OP_READ     = 2'd2,
    OP_RSVD     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_BAD_BASE = 2'd1,
    ST_READ     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_COUNT,
    ACT_BAD,
    ACT_READ
  } action_t;

  typedef struct packed {
    logic                   ok;
    logic [SYMBOL_BITS-1:0] sym;
  } base_t;

  function automatic base_t base_lookup(input logic [7:0] b);
    base_t r;
    r.ok  = 1'b1;
    r.sym = '0;
    case (b)
      CH_A:    r.sym = SYMBOL_BITS'(0);
      CH_C:    r.sym = SYMBOL_BITS'(1);
      CH_G:    r.sym = SYMBOL_BITS'(2);
      CH_T:    r.sym = SYMBOL_BITS'(3);
      CH_N:    r.sym = SYMBOL_BITS'(4);
      default: r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/fastq_barcode_prefix_histogram_top.sv */
// FASTQ read-prefix histogram: record parser, 4096-bin counter store, result register.
//
//   channel | ports                                          | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid in_ready in_opcode in_data_byte       | in
//           | in_read_index                                  |
//   out     | out_valid out_ready out_status out_bin_code    | out
//           | out_bin_count                                  |
//   cfg     | cfg_we cfg_wdata (min read length)             | in
//
// One item per cycle while in_ready is high. A result passes the input register,
// the store read and the result register on its way to out_valid; the store's
// single write port and registered read shape this path, with a one-entry bypass
// for back-to-back hits. After reset a clearing pass zeroes the store with in_ready
// low. A stalled output holds the two stages behind it; bytes that give no result
// keep flowing.
module fastq_barcode_prefix_histogram_top
  import fbph_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [7:0]            in_data_byte,
  input  logic [CODE_BITS-1:0]  in_read_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [CODE_BITS-1:0]  out_bin_code,
  output logic [COUNT_BITS-1:0] out_bin_count,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_wdata
);

  logic [CFG_BITS-1:0]   min_len_r;
  logic [CFG_BITS-1:0]   eff_len;

  // store clearing
  logic                  clearing_r;
  logic [CODE_BITS-1:0]  clr_addr_r;

  // input stage
  logic                  s1_valid_r;
  opcode_t               s1_opcode_r;
  logic [7:0]            s1_byte_r;
  logic [CODE_BITS-1:0]  s1_index_r;

  // parser state
  logic [1:0]            record_line_r,  record_line_nxt;
  logic                  line_start_r,   line_start_nxt;
  logic [SKIP_BITS-1:0]  skip_left_r,    skip_left_nxt;
  logic [POS_BITS-1:0]   prefix_pos_r,   prefix_pos_nxt;
  logic [CODE_BITS-1:0]  prefix_accum_r, prefix_accum_nxt;
  logic                  prefix_bad_r,   prefix_bad_nxt;

  action_t               s1_act;
  logic [CODE_BITS-1:0]  s1_code;
  logic                  take;
  logic [CODE_BITS-1:0]  accum_in;
  logic                  bad_in;
  base_t                 lk;
  logic [CODE_BITS-1:0]  accum_new;
  logic                  bad_new;
  logic [POS_BITS-1:0]   pos_new;

  // store stage
  logic                  s2_valid_r;
  action_t               s2_act_r;
  logic [CODE_BITS-1:0]  s2_code_r;
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic [COUNT_BITS-1:0] store [STORE_DEPTH];
  logic                  mem_we;
  logic [CODE_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  // result register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [CODE_BITS-1:0]  out_code_r;
  logic [COUNT_BITS-1:0] out_count_r;

  // flow control
  logic                  out_free, s2_free, s2_move, s1_done, s1_move, in_xfer;

  assign out_free = !out_valid_r || out_ready;
  assign s2_move  = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_done  = s1_valid_r && ((s1_act == ACT_NONE) || s2_free);
  assign s1_move  = s1_valid_r && (s1_act != ACT_NONE) && s2_free;
  assign in_ready = !clearing_r && (!s1_valid_r || s1_done);
  assign in_xfer  = in_valid && in_ready;

  assign eff_len = (min_len_r == '0) ? CFG_BITS'(1) : min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= CFG_BITS'(1);
    end else if (cfg_we) begin
      min_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + CODE_BITS'(1);
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  // opcode gets a known value at reset so the decoder never sees an unknown
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_opcode_r <= OP_RSVD;
    end else if (in_xfer) begin
      s1_opcode_r <= opcode_t'(in_opcode);
      s1_byte_r   <= in_data_byte;
      s1_index_r  <= in_read_index;
    end
  end

  // record parser: one byte per cycle out of the input register, while the store stage can take a finished prefix
  always_comb begin
    record_line_nxt  = record_line_r;
    line_start_nxt   = line_start_r;
    skip_left_nxt    = skip_left_r;
    prefix_pos_nxt   = prefix_pos_r;
    prefix_accum_nxt = prefix_accum_r;
    prefix_bad_nxt   = prefix_bad_r;
    s1_act           = ACT_NONE;
    s1_code          = s1_index_r;
    take             = 1'b0;
    accum_in         = prefix_accum_r;
    bad_in           = prefix_bad_r;

    unique case (s1_opcode_r)
      OP_NEW_FILE: begin
        record_line_nxt  = '0;
        line_start_nxt   = 1'b0;
        skip_left_nxt    = '0;
        prefix_pos_nxt   = '0;
        prefix_accum_nxt = '0;
        prefix_bad_nxt   = 1'b0;
      end
      OP_READ: begin
        s1_act = ACT_READ;
      end
      OP_BYTE: begin
        if (skip_left_r != '0) begin
          skip_left_nxt = skip_left_r - SKIP_BITS'(1);
        end else if (prefix_pos_r != '0) begin
          take = 1'b1;
        end else if (s1_byte_r == CH_NL) begin
          record_line_nxt = record_line_r + 2'd1;
          line_start_nxt  = 1'b1;
        end else if (line_start_r) begin
          line_start_nxt = 1'b0;
          if (record_line_r == 2'd1) begin
            take     = 1'b1;
            accum_in = '0;
            bad_in   = 1'b0;
          end else if (record_line_r == 2'd3) begin
            // quality line: skip the read length plus the rest of the prefix width
            skip_left_nxt = SKIP_BITS'(eff_len) + SKIP_BITS'(PREFIX_LEN - 1);
          end
        end
      end
      OP_RSVD: begin
      end
      default: begin
      end
    endcase

    lk        = base_lookup(s1_byte_r);
    accum_new = {accum_in[CODE_BITS-SYMBOL_BITS-1:0], lk.sym};
    bad_new   = bad_in | ~lk.ok;
    pos_new   = prefix_pos_r + POS_BITS'(1);

    if (take) begin
      if (pos_new == POS_BITS'(PREFIX_LEN)) begin
        skip_left_nxt    = SKIP_BITS'(eff_len);
        prefix_pos_nxt   = '0;
        prefix_accum_nxt = '0;
        prefix_bad_nxt   = 1'b0;
        s1_act           = bad_new ? ACT_BAD : ACT_COUNT;
        s1_code          = accum_new;
      end else begin
        prefix_pos_nxt   = pos_new;
        prefix_accum_nxt = accum_new;
        prefix_bad_nxt   = bad_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_line_r  <= '0;
      line_start_r   <= 1'b0;
      skip_left_r    <= '0;
      prefix_pos_r   <= '0;
      prefix_accum_r <= '0;
      prefix_bad_r   <= 1'b0;
    end else if (s1_done) begin
      record_line_r  <= record_line_nxt;
      line_start_r   <= line_start_nxt;
      skip_left_r    <= skip_left_nxt;
      prefix_pos_r   <= prefix_pos_nxt;
      prefix_accum_r <= prefix_accum_nxt;
      prefix_bad_r   <= prefix_bad_nxt;
    end
  end

  // counter store: clearing pass or increment write, registered read
  assign cnt_cur   = fwd_hit_r ? fwd_data_r : mem_q_r;
  assign cnt_inc   = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
  assign mem_we    = clearing_r || (s2_move && (s2_act_r == ACT_COUNT));
  assign mem_waddr = clearing_r ? clr_addr_r : s2_code_r;
  assign mem_wdata = clearing_r ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (s1_move) begin
      mem_q_r <= store[s1_code];
    end
  end

  // the read above misses a write to the same bin in the same cycle
  always_ff @(posedge clk) begin
    if (s1_move) begin
      fwd_hit_r  <= s2_move && (s2_act_r == ACT_COUNT) && (s2_code_r == s1_code);
      fwd_data_r <= cnt_inc;
      s2_act_r   <= s1_act;
      s2_code_r  <= s1_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_move) begin
      s2_valid_r <= 1'b1;
    end else if (s2_move) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      case (s2_act_r)
        ACT_COUNT: begin
          out_status_r <= ST_COUNTED;
          out_code_r   <= s2_code_r;
          out_count_r  <= cnt_inc;
        end
        ACT_READ: begin
          out_status_r <= ST_READ;
          out_code_r   <= s2_code_r;
          out_count_r  <= cnt_cur;
        end
        default: begin
          out_status_r <= ST_BAD_BASE;
          out_code_r   <= '0;
          out_count_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bin_code  = out_code_r;
  assign out_bin_count = out_count_r;

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ready)
    else $error("input taken during store clearing");

  a_pipe_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!s1_valid_r && !s2_valid_r && !out_valid_r))
    else $error("pipeline busy during store clearing");

  a_prefix_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    prefix_pos_r < POS_BITS'(PREFIX_LEN))
    else $error("prefix position out of range");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_COUNTED)) |-> (out_count_r != '0))
    else $error("counted prefix reports zero");

endmodule

/* tb/prefix_histogram_checker.sv */
// Checker for the FASTQ prefix histogram: tracks transfers, predicts results, compares them.
module prefix_histogram_checker
  import fbph_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [7:0]            in_data_byte,
  input  logic [CODE_BITS-1:0]  in_read_index,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            out_status,
  input  logic [CODE_BITS-1:0]  out_bin_code,
  input  logic [COUNT_BITS-1:0] out_bin_count,
  input  logic                  cfg_we,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  output int                    mismatch_count,
  output int                    results_owed
);

  typedef struct packed {
    status_t                status;
    logic [CODE_BITS-1:0]   code;
    logic [COUNT_BITS-1:0]  count;
  } bin_result_t;

  bin_result_t            owed_results[$];
  logic [COUNT_BITS-1:0]  bin_tally [STORE_DEPTH];
  logic [CFG_BITS-1:0]    read_len;
  logic [1:0]             line_no;
  bit                     line_start;
  logic [SKIP_BITS-1:0]   skip_cnt;
  logic [POS_BITS-1:0]    base_cnt;
  logic [CODE_BITS-1:0]   code_acc;
  bit                     code_bad;

  // zero length behaves as one
  function automatic logic [SKIP_BITS-1:0] skip_after_prefix();
    return (read_len == '0) ? SKIP_BITS'(1) : SKIP_BITS'(read_len);
  endfunction

  task automatic clear_parser();
    line_no    = '0;
    line_start = 1'b0;
    skip_cnt   = '0;
    base_cnt   = '0;
    code_acc   = '0;
    code_bad   = 1'b0;
  endtask

  task automatic collect_base(input logic [7:0] b);
    logic [SYMBOL_BITS-1:0] sym;
    bin_result_t            r;
    sym = '0;
    case (b)
      CH_A:    sym = SYMBOL_BITS'(0);
      CH_C:    sym = SYMBOL_BITS'(1);
      CH_G:    sym = SYMBOL_BITS'(2);
      CH_T:    sym = SYMBOL_BITS'(3);
      CH_N:    sym = SYMBOL_BITS'(4);
      default: code_bad = 1'b1;
    endcase
    code_acc = {code_acc[CODE_BITS-SYMBOL_BITS-1:0], sym};
    base_cnt++;
    if (base_cnt == POS_BITS'(PREFIX_LEN)) begin
      skip_cnt = skip_after_prefix();
      base_cnt = '0;
      if (code_bad) begin
        r = '{ST_BAD_BASE, '0, '0};
      end else begin
        if (bin_tally[code_acc] != COUNT_MAX) bin_tally[code_acc]++;
        r = '{ST_COUNTED, code_acc, bin_tally[code_acc]};
      end
      owed_results.push_back(r);
      code_acc = '0;
      code_bad = 1'b0;
    end
  endtask

  // skipped bytes and prefix bases are never looked at for newlines
  task automatic track_byte(input logic [7:0] b);
    if (skip_cnt != '0) begin
      skip_cnt--;
    end else if (base_cnt != '0) begin
      collect_base(b);
    end else if (b == CH_NL) begin
      line_no++;
      line_start = 1'b1;
    end else if (line_start) begin
      line_start = 1'b0;
      if (line_no == 2'd1) begin
        code_acc = '0;
        code_bad = 1'b0;
        collect_base(b);
      end else if (line_no == 2'd3) begin
        skip_cnt = skip_after_prefix() + SKIP_BITS'(PREFIX_LEN - 1);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    bin_result_t r;
    if (!rst_n) begin
      clear_parser();
      read_len = CFG_BITS'(1);
      foreach (bin_tally[i]) bin_tally[i] = '0;
      owed_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) read_len = cfg_wdata;
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: out_status %0d out_bin_code %0h out_bin_count %0d",
                 out_status, out_bin_code, out_bin_count);
          mismatch_count++;
        end else begin
          r = owed_results.pop_front();
          if (out_status != r.status) begin
            $error("out_status: expected %0d, actual %0d", r.status, out_status);
            mismatch_count++;
          end
          if (out_bin_code != r.code) begin
            $error("out_bin_code: expected %0h, actual %0h", r.code, out_bin_code);
            mismatch_count++;
          end
          if (out_bin_count != r.count) begin
            $error("out_bin_count: expected %0d, actual %0d", r.count, out_bin_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (opcode_t'(in_opcode))
          OP_BYTE:     track_byte(in_data_byte);
          OP_NEW_FILE: clear_parser();
          OP_READ:     owed_results.push_back('{ST_READ, in_read_index,
                                                bin_tally[in_read_index]});
          default: ;
        endcase
      end
    end
    results_owed = owed_results.size();
  end

endmodule

/* tb/tb_fastq_barcode_prefix_histogram_top.sv */
// Testbench top for the FASTQ prefix histogram: clock, reset, stimulus and verdict.
module tb_fastq_barcode_prefix_histogram_top;
  import fbph_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_ITEMS = 320;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_QUAL     = 8'h49;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_opcode;
  logic [7:0]            in_data_byte;
  logic [CODE_BITS-1:0]  in_read_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_status;
  logic [CODE_BITS-1:0]  out_bin_code;
  logic [COUNT_BITS-1:0] out_bin_count;
  logic                  cfg_we;
  logic [CFG_BITS-1:0]   cfg_wdata;

  int mismatch_count;
  int results_owed;
  int sent_items;
  int cur_len;
  bit calm;
  bit hold_req;
  bit gaps_on;

  fastq_barcode_prefix_histogram_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_data_byte  (in_data_byte),
    .in_read_index (in_read_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_bin_code  (out_bin_code),
    .out_bin_count (out_bin_count),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  prefix_histogram_checker hist_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_data_byte   (in_data_byte),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_bin_code   (out_bin_code),
    .out_bin_count  (out_bin_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stalls, quiet stretches, one long hold-off on request
  initial begin : sink
    int  n;
    bit  hold_done;
    bit  quiet;
    hold_done = 1'b0;
    quiet     = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) quiet = !quiet;
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic push_item(input opcode_t op, input logic [7:0] b,
                           input logic [CODE_BITS-1:0] idx);
    if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_data_byte  <= b;
    in_read_index <= idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    push_item(OP_BYTE, b, CODE_BITS'($urandom));
  endtask

  // register changes only with the block drained: no results owed and no bytes in flight
  task automatic write_len(input logic [CFG_BITS-1:0] v);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_len = v;
  endtask

  // one four-line record; prefixes lean on A/C so a few bins fill up
  task automatic send_record();
    int         eff;
    int         seq_n;
    logic [7:0] b;
    eff     = (cur_len == 0) ? 1 : cur_len;
    gaps_on = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom);
      if (b == CH_NL) b = CH_AT;
      put_byte(b);
    end
    put_byte(CH_NL);
    seq_n = PREFIX_LEN + eff + $urandom_range(0, 4);
    // short line: its newline gets swallowed and the record framing breaks
    if ($urandom_range(0, 11) == 0) seq_n = $urandom_range(1, PREFIX_LEN + eff - 1);
    for (int i = 0; i < seq_n; i++) begin
      if (i < PREFIX_LEN && $urandom_range(0, 24) == 0) begin
        b = 8'($urandom);
      end else if (i < PREFIX_LEN && $urandom_range(0, 1) == 1) begin
        b = $urandom_range(0, 1) ? CH_A : CH_C;
      end else begin
        case ($urandom_range(0, 4))
          0:       b = CH_A;
          1:       b = CH_C;
          2:       b = CH_G;
          3:       b = CH_T;
          default: b = CH_N;
        endcase
      end
      put_byte(b);
    end
    put_byte(CH_NL);
    put_byte(CH_PLUS);
    put_byte(CH_NL);
    repeat (seq_n) put_byte(8'($urandom_range(33, 126)));
    put_byte(CH_NL);
    if (seq_n < PREFIX_LEN + eff && $urandom_range(0, 1) == 1)
      push_item(OP_NEW_FILE, 8'($urandom), CODE_BITS'($urandom));
  endtask

  task automatic send_noise();
    logic [3:0]           r;
    logic [CODE_BITS-1:0] idx;
    r   = 4'($urandom);
    idx = {2'b00, r[3], 2'b00, r[2], 2'b00, r[1], 2'b00, r[0]};
    case ($urandom_range(0, 4))
      0:       push_item(OP_READ, 8'($urandom), CODE_BITS'($urandom));
      1:       push_item(OP_READ, 8'($urandom), idx);
      2:       push_item(OP_RSVD, 8'($urandom), CODE_BITS'($urandom));
      3:       push_item(OP_NEW_FILE, 8'($urandom), CODE_BITS'($urandom));
      default: put_byte(8'($urandom));
    endcase
  endtask

  initial begin : stimulus
    logic [CFG_BITS-1:0] len_plan [7];
    int                  phase_end;
    len_plan = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd5, 16'd3, 16'd1};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_BYTE;
    in_data_byte  = '0;
    in_read_index = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    gaps_on       = 1'b1;
    sent_items    = 0;
    cur_len       = 1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: first byte is no line start, all-N prefix, quality skip,
    // newline inside a prefix, reserved opcode, restart, reads of the all-N bin and the top index
    put_byte(CH_A);
    put_byte(CH_NL);
    repeat (4) put_byte(CH_N);
    put_byte(8'hFF);
    put_byte(CH_NL);
    put_byte(CH_PLUS);
    put_byte(CH_NL);
    put_byte(8'h00);
    repeat (4) put_byte(CH_QUAL);
    put_byte(CH_NL);
    put_byte(CH_NL);
    put_byte(CH_A);
    put_byte(CH_C);
    put_byte(CH_NL);
    put_byte(CH_T);
    push_item(OP_RSVD, 8'hFF, 12'hFFF);
    push_item(OP_NEW_FILE, 8'h00, 12'h000);
    push_item(OP_READ, 8'h00, 12'h924);
    push_item(OP_READ, 8'hFF, 12'hFFF);

    foreach (len_plan[p]) begin
      write_len(len_plan[p]);
      if (p == 2) hold_req = 1'b1;
      if (p == 6) calm = 1'b1;
      if (len_plan[p] == 16'hFFFF) begin
        // longest skip: only reads and a restart get through it
        push_item(OP_NEW_FILE, 8'h00, 12'h000);
        put_byte(CH_NL);
        put_byte(CH_A);
        put_byte(CH_C);
        put_byte(CH_G);
        put_byte(CH_T);
        repeat (20) put_byte(8'($urandom));
        push_item(OP_READ, 8'($urandom), 12'h053);
        push_item(OP_READ, 8'($urandom), CODE_BITS'($urandom));
        push_item(OP_NEW_FILE, 8'($urandom), CODE_BITS'($urandom));
      end else begin
        phase_end = sent_items + PHASE_ITEMS;
        while (sent_items < phase_end) begin
          if ($urandom_range(0, 5) == 0) send_noise();
          send_record();
        end
      end
    end

    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* fastq_barcode_prefix_histogram_top.f */
rtl/fbph_pkg.sv
rtl/fastq_barcode_prefix_histogram_top.sv
tb/prefix_histogram_checker.sv
tb/tb_fastq_barcode_prefix_histogram_top.sv
